// File: design/kcc_pkg.sv
// kcc_pkg: shared types, constants and helpers for the key click classifier
// used by kcc_key_lane, key_click_classifier and kcc_checker; no dependencies
`default_nettype none

package kcc_pkg;

    // key count and field widths
    localparam int KCC_NUM_KEYS   = 4;
    localparam int KCC_MAX_KEYS   = 4;
    localparam int KCC_LEVEL_W    = 4;
    localparam int KCC_CODE_W     = 4;
    localparam int KCC_HOLD_W     = 8;
    localparam int KCC_CLICK_W    = 2;
    localparam int KCC_AGE_W      = 4;
    localparam int KCC_LIMIT_W    = 4;
    localparam int KCC_POLLS_W    = 8;
    localparam int KCC_CFG_IDX_W  = 1;
    localparam int KCC_CFG_DATA_W = 8;

    // register reset values
    localparam logic [KCC_LIMIT_W-1:0] KCC_WINDOW_LIMIT_RST = 4'd3;
    localparam logic [KCC_POLLS_W-1:0] KCC_LONG_POLLS_RST   = 8'd10;

    // counter ceilings
    localparam logic [KCC_HOLD_W-1:0]  KCC_HOLD_MAX  = '1;
    localparam logic [KCC_CLICK_W-1:0] KCC_CLICK_MAX = '1;
    localparam logic [KCC_AGE_W-1:0]   KCC_AGE_MAX   = '1;

    // request types
    localparam logic KCC_REQ_POLL = 1'b0;
    localparam logic KCC_REQ_TICK = 1'b1;

    // configuration register indexes
    localparam logic [KCC_CFG_IDX_W-1:0] KCC_CFG_WINDOW_LIMIT = 1'b0;
    localparam logic [KCC_CFG_IDX_W-1:0] KCC_CFG_LONG_POLLS   = 1'b1;

    // result codes
    localparam logic [KCC_CODE_W-1:0] KCC_CODE_NONE        = 4'd0;
    localparam logic [KCC_CODE_W-1:0] KCC_CODE_SINGLE_BASE = 4'd1;
    localparam logic [KCC_CODE_W-1:0] KCC_CODE_DOUBLE_BASE = 4'd5;
    localparam logic [KCC_CODE_W-1:0] KCC_CODE_LONG_BASE   = 4'd9;
    localparam logic [KCC_CODE_W-1:0] KCC_CODE_MAX         = 4'd12;

    // per-key counters
    typedef struct packed {
        logic [KCC_HOLD_W-1:0]  hold;
        logic [KCC_CLICK_W-1:0] clicks;
        logic [KCC_AGE_W-1:0]   age;
    } t_kcc_key_state;

    // per-key events of one item
    typedef struct packed {
        logic close;
        logic single;
        logic long_press;
    } t_kcc_key_rpt;

    // code for a key index added to a code base
    function automatic logic [KCC_CODE_W-1:0] kcc_key_code(
        input logic [KCC_CODE_W-1:0] base,
        input logic [1:0]            idx
    );
        return base + {2'b00, idx};
    endfunction

endpackage

`default_nettype wire

// File: design/key_click_classifier.sv
// key_click_classifier: top level of the single, double and long press classifier
// depends on kcc_pkg and kcc_key_lane
`default_nettype none

// Accepts one tick or poll item per clock cycle while ready is high and
// returns exactly one key code per item, in order. All per-key counters
// update in a single register stage at the input transfer, and the code is
// registered into the output buffer. This two-entry buffer (output register
// plus skid register) keeps input ready high while one result waits; input
// ready drops only when both entries are full. Configuration writes are
// taken every cycle and should only be issued while the block is idle.
module key_click_classifier #(
    parameter int NUM_KEYS = kcc_pkg::KCC_NUM_KEYS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // item input
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_req_type,
    input  wire logic [kcc_pkg::KCC_LEVEL_W-1:0]    i_first_levels,
    input  wire logic [kcc_pkg::KCC_LEVEL_W-1:0]    i_confirm_levels,
    // result output
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [kcc_pkg::KCC_CODE_W-1:0]          o_key_code,
    // configuration writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [kcc_pkg::KCC_CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [kcc_pkg::KCC_CFG_DATA_W-1:0] i_cfg_data
);
    import kcc_pkg::*;

    logic [KCC_LIMIT_W-1:0] r_window_limit;
    logic [KCC_POLLS_W-1:0] r_long_polls;
    logic                   r_ticks_seen;
    t_kcc_key_state         r_key [NUM_KEYS];
    t_kcc_key_state         n_key [NUM_KEYS];
    t_kcc_key_rpt           w_rpt [NUM_KEYS];

    logic                   r_out_valid;
    logic [KCC_CODE_W-1:0]  r_out_code;
    logic                   r_skid_valid;
    logic [KCC_CODE_W-1:0]  r_skid_code;
    logic [KCC_CODE_W-1:0]  n_code;

    logic w_in_xfer;
    logic w_out_xfer;
    logic w_is_tick;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_xfer  = r_out_valid && i_out_ready;
    assign w_is_tick   = (i_req_type == KCC_REQ_TICK);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_limit <= KCC_WINDOW_LIMIT_RST;
            r_long_polls   <= KCC_LONG_POLLS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                KCC_CFG_WINDOW_LIMIT: r_window_limit <= i_cfg_data[KCC_LIMIT_W-1:0];
                KCC_CFG_LONG_POLLS:   r_long_polls   <= i_cfg_data[KCC_POLLS_W-1:0];
                default: ;
            endcase
        end
    end

    // one lane per key
    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
        kcc_key_lane u_lane (
            .i_is_tick          (w_is_tick),
            .i_ticks_seen       (r_ticks_seen),
            .i_first_low        (!i_first_levels[g]),
            .i_confirm_low      (!i_confirm_levels[g]),
            .i_window_limit     (r_window_limit),
            .i_long_press_polls (r_long_polls),
            .i_state            (r_key[g]),
            .o_state            (n_key[g]),
            .o_rpt              (w_rpt[g])
        );

        // key counters
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_key[g] <= '0;
            end else if (w_in_xfer) begin
                r_key[g] <= n_key[g];
            end
        end
    end

    // tick seen flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_seen <= 1'b0;
        end else if (w_in_xfer && w_is_tick) begin
            r_ticks_seen <= 1'b1;
        end
    end

    // result code: closings first, long presses after, later key wins
    always_comb begin
        n_code = KCC_CODE_NONE;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (w_rpt[k].close) begin
                n_code = kcc_key_code(w_rpt[k].single ? KCC_CODE_SINGLE_BASE
                                                      : KCC_CODE_DOUBLE_BASE, 2'(k));
            end
        end
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (w_rpt[k].long_press) begin
                n_code = kcc_key_code(KCC_CODE_LONG_BASE, 2'(k));
            end
        end
    end

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_xfer) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_xfer) begin
            if (!r_out_valid || w_out_xfer) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_xfer) begin
                r_out_code <= r_skid_code;
            end
        end else if (w_in_xfer) begin
            if (!r_out_valid || w_out_xfer) begin
                r_out_code <= n_code;
            end else begin
                r_skid_code <= n_code;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_code  = r_out_code;

endmodule

`default_nettype wire

// File: design/kcc_key_lane.sv
// kcc_key_lane: next-state and event logic for one key of the classifier
// depends on kcc_pkg
`default_nettype none

module kcc_key_lane (
    input  wire logic                            i_is_tick,
    input  wire logic                            i_ticks_seen,
    input  wire logic                            i_first_low,
    input  wire logic                            i_confirm_low,
    input  wire logic [kcc_pkg::KCC_LIMIT_W-1:0] i_window_limit,
    input  wire logic [kcc_pkg::KCC_POLLS_W-1:0] i_long_press_polls,
    input  wire kcc_pkg::t_kcc_key_state         i_state,
    output kcc_pkg::t_kcc_key_state              o_state,
    output kcc_pkg::t_kcc_key_rpt                o_rpt
);
    import kcc_pkg::*;

    t_kcc_key_state n_state;
    t_kcc_key_rpt   n_rpt;

    // tick ages an open window, poll closes and then samples
    always_comb begin
        n_state = i_state;
        n_rpt   = '0;
        if (i_is_tick) begin
            if (n_state.clicks != '0 && n_state.age != KCC_AGE_MAX) begin
                n_state.age = n_state.age + 1'b1;
            end
        end else begin
            // window closing
            if (n_state.age > i_window_limit) begin
                n_rpt.close    = 1'b1;
                n_rpt.single   = (n_state.clicks == KCC_CLICK_W'(1));
                n_state.age    = '0;
                n_state.clicks = '0;
            end
            // sampling once a tick has been seen
            if (i_ticks_seen) begin
                if (i_first_low) begin
                    if (i_confirm_low) begin
                        if (n_state.hold != KCC_HOLD_MAX) begin
                            n_state.hold = n_state.hold + 1'b1;
                        end
                        if (n_state.hold >= i_long_press_polls) begin
                            n_rpt.long_press = 1'b1;
                        end
                    end
                end else begin
                    if (n_state.hold != '0 && n_state.hold < i_long_press_polls
                        && n_state.clicks != KCC_CLICK_MAX) begin
                        n_state.clicks = n_state.clicks + 1'b1;
                    end
                    n_state.hold = '0;
                end
            end
        end
    end

    assign o_state = n_state;
    assign o_rpt   = n_rpt;

endmodule

`default_nettype wire

// File: design/kcc_checker.sv
// kcc_checker: port-level assertions for key_click_classifier, bound to the top
// depends on kcc_pkg and key_click_classifier
`default_nettype none

module kcc_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               o_in_ready,
    input wire logic                               i_req_type,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_ready,
    input wire logic [kcc_pkg::KCC_CODE_W-1:0]     o_key_code
);
    import kcc_pkg::*;

    // a waiting result holds its code
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_key_code))
        else $error("result changed while stalled");

    // tick transfer into an empty output gives code none next cycle
    a_tick_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_req_type == KCC_REQ_TICK) && !o_out_valid
        |=> o_out_valid && (o_key_code == KCC_CODE_NONE))
        else $error("tick did not give code none");

    // codes stay in their defined range
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_key_code <= KCC_CODE_MAX)
        else $error("key code out of range");

    // input stalls only with a result pending
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind key_click_classifier kcc_checker u_kcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_req_type  (i_req_type),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_key_code  (o_key_code)
);

`default_nettype wire

// File: dv/tb_key_click_classifier.sv
// tb_key_click_classifier: self-checking testbench for the key click classifier
// drives tick and poll transfers, predicts every key code, checks them in order
// depends on kcc_pkg and key_click_classifier
`timescale 1ns / 100ps

module tb_key_click_classifier;

    import kcc_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // one row of the directed table; known marks a code typed in by hand
    typedef struct packed {
        logic                  req;
        logic [KCC_LEVEL_W-1:0] first;
        logic [KCC_LEVEL_W-1:0] confirm;
        logic                  known;
        logic [KCC_CODE_W-1:0] code;
    } t_click_row;

    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 140;
    localparam int HOLD_BURST_LEN = 260;
    localparam int MAX_REPORTS    = 50;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      in_valid;
    logic                      o_in_ready;
    logic                      req_type;
    logic [KCC_LEVEL_W-1:0]    first_levels;
    logic [KCC_LEVEL_W-1:0]    confirm_levels;
    logic                      o_out_valid;
    logic                      out_ready;
    logic [KCC_CODE_W-1:0]     o_key_code;
    logic                      cfg_valid;
    logic                      o_cfg_ready;
    logic [KCC_CFG_IDX_W-1:0]  cfg_index;
    logic [KCC_CFG_DATA_W-1:0] cfg_data;

    // hand-typed code riding along with the current input transfer
    logic                  row_known;
    logic [KCC_CODE_W-1:0] row_code;

    // predicted block state and configuration
    logic [KCC_LIMIT_W-1:0] win_limit;
    logic [KCC_POLLS_W-1:0] lp_polls;
    logic                   ticks_seen;
    logic [KCC_HOLD_W-1:0]  hold_cnt  [KCC_NUM_KEYS];
    logic [KCC_CLICK_W-1:0] click_cnt [KCC_NUM_KEYS];
    logic [KCC_AGE_W-1:0]   win_age   [KCC_NUM_KEYS];

    logic [KCC_CODE_W-1:0] pending_codes [$];
    int                    err_count = 0;
    int                    tx_gap_pct = 0;
    int                    rx_stall_pct = 0;

    // per-key press pattern of the random stimulus
    logic key_down [KCC_NUM_KEYS];
    int   run_left [KCC_NUM_KEYS];

    t_click_row dir_rows [22];

    key_click_classifier i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (req_type),
        .i_first_levels   (first_levels),
        .i_confirm_levels (confirm_levels),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_key_code       (o_key_code),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // watchdog
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // classify one item against the predicted state and advance it
    function automatic logic [KCC_CODE_W-1:0] predict_key_code(
        input logic                   req,
        input logic [KCC_LEVEL_W-1:0] first,
        input logic [KCC_LEVEL_W-1:0] confirm
    );
        logic [KCC_CODE_W-1:0] code;
        code = KCC_CODE_NONE;
        // tick: enable sampling and age open windows
        if (req == KCC_REQ_TICK) begin
            ticks_seen = 1'b1;
            for (int k = 0; k < KCC_NUM_KEYS; k++)
                if (click_cnt[k] != '0 && win_age[k] != KCC_AGE_MAX)
                    win_age[k] = win_age[k] + 1'b1;
            return KCC_CODE_NONE;
        end
        // close expired windows
        for (int k = 0; k < KCC_NUM_KEYS; k++) begin
            if (win_age[k] > win_limit) begin
                code = (click_cnt[k] == 2'd1) ? KCC_CODE_SINGLE_BASE + 4'(k)
                                             : KCC_CODE_DOUBLE_BASE + 4'(k);
                win_age[k]   = '0;
                click_cnt[k] = '0;
            end
        end
        // sample keys once a tick has been seen
        if (ticks_seen) begin
            for (int k = 0; k < KCC_NUM_KEYS; k++) begin
                if (!first[k]) begin
                    if (!confirm[k]) begin
                        if (hold_cnt[k] != KCC_HOLD_MAX)
                            hold_cnt[k] = hold_cnt[k] + 1'b1;
                        if (hold_cnt[k] >= lp_polls)
                            code = KCC_CODE_LONG_BASE + 4'(k);
                    end
                end else begin
                    if (hold_cnt[k] != '0 && hold_cnt[k] < lp_polls
                        && click_cnt[k] != KCC_CLICK_MAX)
                        click_cnt[k] = click_cnt[k] + 1'b1;
                    hold_cnt[k] = '0;
                end
            end
        end
        return code;
    endfunction

    // monitor: config and input transfers update the prediction, results are checked
    always @(posedge i_clk) begin : monitor
        logic [KCC_CODE_W-1:0] predicted;
        logic [KCC_CODE_W-1:0] exp_code;
        if (i_rst_n) begin
            if (cfg_valid && o_cfg_ready) begin
                if (cfg_index == KCC_CFG_WINDOW_LIMIT)
                    win_limit = cfg_data[KCC_LIMIT_W-1:0];
                else
                    lp_polls = cfg_data;
            end
            if (in_valid && o_in_ready) begin
                predicted = predict_key_code(req_type, first_levels, confirm_levels);
                pending_codes.push_back(row_known ? row_code : predicted);
            end
            if (o_out_valid && out_ready) begin
                if (pending_codes.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: unexpected key_code %0d, expected none",
                                 $time, o_key_code);
                end else begin
                    exp_code = pending_codes.pop_front();
                    if (o_key_code !== exp_code) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("%0t: key_code mismatch, expected %0d, got %0d",
                                     $time, exp_code, o_key_code);
                    end
                end
            end
        end
    end

    // one input transfer; entered and left at a falling edge
    task automatic send_item(
        input logic                   req,
        input logic [KCC_LEVEL_W-1:0] first,
        input logic [KCC_LEVEL_W-1:0] confirm,
        input logic                   known,
        input logic [KCC_CODE_W-1:0]  code
    );
        while ($urandom_range(99) < tx_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid       <= 1'b1;
        req_type       <= req;
        first_levels   <= first;
        confirm_levels <= confirm;
        row_known      <= known;
        row_code       <= code;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // wait for the block to empty, then write one register
    task automatic write_reg(
        input logic [KCC_CFG_IDX_W-1:0]  idx,
        input logic [KCC_CFG_DATA_W-1:0] data
    );
        in_valid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly realistic press and release runs with ticks; some pure noise
    task automatic make_random_item(
        output logic                   req,
        output logic [KCC_LEVEL_W-1:0] first,
        output logic [KCC_LEVEL_W-1:0] confirm
    );
        int cap;
        first   = KCC_LEVEL_W'($urandom);
        confirm = KCC_LEVEL_W'($urandom);
        if ($urandom_range(99) < 10) begin
            req = 1'($urandom_range(1));
            return;
        end
        if ($urandom_range(99) < 30) begin
            req = KCC_REQ_TICK;
            return;
        end
        req = KCC_REQ_POLL;
        cap = (lp_polls > 8'd30) ? 30 : int'(lp_polls) + 2;
        for (int k = 0; k < KCC_NUM_KEYS; k++) begin
            if (run_left[k] == 0) begin
                key_down[k] = !key_down[k];
                if (key_down[k])
                    run_left[k] = ($urandom_range(99) < 20) ? $urandom_range(cap, 1)
                                                           : $urandom_range(3, 1);
                else
                    run_left[k] = $urandom_range(5, 1);
            end
            run_left[k]--;
            first[k] = !key_down[k];
            if ($urandom_range(99) < 5)
                first[k] = !first[k];
            confirm[k] = first[k];
            if ($urandom_range(99) < 8)
                confirm[k] = !confirm[k];
        end
    endtask

    // stimulus
    initial begin : stimulus
        logic                   req;
        logic [KCC_LEVEL_W-1:0] first;
        logic [KCC_LEVEL_W-1:0] confirm;
        logic [KCC_CFG_DATA_W-1:0] limit_data [NUM_PHASES];
        logic [KCC_CFG_DATA_W-1:0] polls_data [NUM_PHASES];

        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        req_type       = KCC_REQ_POLL;
        first_levels   = '1;
        confirm_levels = '1;
        row_known      = 1'b0;
        row_code       = KCC_CODE_NONE;
        cfg_valid      = 1'b0;
        cfg_index      = KCC_CFG_WINDOW_LIMIT;
        cfg_data       = '0;

        // predicted state after reset
        win_limit  = KCC_WINDOW_LIMIT_RST;
        lp_polls   = KCC_LONG_POLLS_RST;
        ticks_seen = 1'b0;
        for (int k = 0; k < KCC_NUM_KEYS; k++) begin
            hold_cnt[k]  = '0;
            click_cnt[k] = '0;
            win_age[k]   = '0;
            key_down[k]  = 1'b0;
            run_left[k]  = 0;
        end

        // directed rows at reset configuration
        dir_rows = '{
            // polls before any tick only close windows
            '{KCC_REQ_POLL, 4'hF, 4'hF, 1'b1, KCC_CODE_NONE},
            '{KCC_REQ_POLL, 4'h0, 4'h0, 1'b1, KCC_CODE_NONE},
            // ticks always report none
            '{KCC_REQ_TICK, 4'h0, 4'h0, 1'b1, KCC_CODE_NONE},
            '{KCC_REQ_TICK, 4'hF, 4'hF, 1'b1, KCC_CODE_NONE},
            // all keys pressed then released: one click each
            '{KCC_REQ_POLL, 4'h0, 4'h0, 1'b0, KCC_CODE_NONE},
            '{KCC_REQ_POLL, 4'hF, 4'hF, 1'b0, KCC_CODE_NONE},
            // first low with confirm high leaves keys alone
            '{KCC_REQ_POLL, 4'h0, 4'hF, 1'b0, KCC_CODE_NONE},
            '{KCC_REQ_POLL, 4'hF, 4'h0, 1'b0, KCC_CODE_NONE},
            // key 0 clicked until its count saturates
            '{KCC_REQ_POLL, 4'hE, 4'hE, 1'b0, KCC_CODE_NONE},
            '{KCC_REQ_POLL, 4'hF, 4'hF, 1'b0, KCC_CODE_NONE},
            '{KCC_REQ_POLL, 4'hE, 4'hE, 1'b0, KCC_CODE_NONE},
            '{KCC_REQ_POLL, 4'hF, 4'hF, 1'b0, KCC_CODE_NONE},
            '{KCC_REQ_POLL, 4'hE, 4'hE, 1'b0, KCC_CODE_NONE},
            '{KCC_REQ_POLL, 4'hF, 4'hF, 1'b0, KCC_CODE_NONE},
            // age windows past the limit
            '{KCC_REQ_TICK, 4'hA, 4'h5, 1'b1, KCC_CODE_NONE},
            '{KCC_REQ_TICK, 4'h5, 4'hA, 1'b1, KCC_CODE_NONE},
            '{KCC_REQ_TICK, 4'h0, 4'hF, 1'b1, KCC_CODE_NONE},
            '{KCC_REQ_TICK, 4'hF, 4'h0, 1'b1, KCC_CODE_NONE},
            // windows close, later keys override key 0 double
            '{KCC_REQ_POLL, 4'hF, 4'hF, 1'b0, KCC_CODE_NONE},
            // alternating key patterns
            '{KCC_REQ_POLL, 4'h5, 4'h5, 1'b0, KCC_CODE_NONE},
            '{KCC_REQ_POLL, 4'hA, 4'hA, 1'b0, KCC_CODE_NONE},
            '{KCC_REQ_POLL, 4'hF, 4'hF, 1'b0, KCC_CODE_NONE}
        };

        // settings per phase, extremes included; upper limit bits are don't-care
        limit_data = '{8'h03, 8'hF1, 8'h0E, 8'h0F, 8'hA5, 8'h00, 8'h02, 8'h53};
        polls_data = '{8'd10, 8'd2, 8'd255, 8'd1, 8'd0, 8'd0, 8'd3, 8'd10};

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].req, dir_rows[i].first, dir_rows[i].confirm,
                      dir_rows[i].known, dir_rows[i].code);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (t_idle_mode'(phase % 4))
                IDLE_NONE:     begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                IDLE_SENDER:   begin tx_gap_pct = 81; rx_stall_pct = 0;  end
                IDLE_RECEIVER: begin tx_gap_pct = 0;  rx_stall_pct = 81; end
                default:       begin tx_gap_pct = 31; rx_stall_pct = 31; end
            endcase
            if (phase != 0) begin
                // one phase takes a random mid-range setting
                if (phase == 5) begin
                    limit_data[phase] = KCC_CFG_DATA_W'($urandom_range(14, 1));
                    polls_data[phase] = KCC_CFG_DATA_W'($urandom_range(40, 2));
                end
                write_reg(KCC_CFG_WINDOW_LIMIT, limit_data[phase]);
                write_reg(KCC_CFG_LONG_POLLS, polls_data[phase]);
            end
            // long hold of every key up to the hold ceiling
            if (polls_data[phase] == 8'd255) begin
                send_item(KCC_REQ_TICK, 4'hF, 4'hF, 1'b1, KCC_CODE_NONE);
                repeat (HOLD_BURST_LEN)
                    send_item(KCC_REQ_POLL, 4'h0, 4'h0, 1'b0, KCC_CODE_NONE);
                send_item(KCC_REQ_POLL, 4'hF, 4'hF, 1'b0, KCC_CODE_NONE);
            end
            repeat (PHASE_ITEMS) begin
                make_random_item(req, first, confirm);
                send_item(req, first, confirm, 1'b0, KCC_CODE_NONE);
            end
        end

        // drain
        in_valid     <= 1'b0;
        rx_stall_pct = 0;
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
